// File: sv/ssas_pkg.sv
// Shared types, constants and the segment table for the seven-segment scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssas_pkg;

    localparam int DIGITS = 4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [7:0]  SEG_POINT_MASK = 8'h7f;
    localparam logic [13:0] SHOWN_MAX      = 14'd9999;
    localparam logic [15:0] PERIOD_RESET   = 16'd2;

    // value a digit is shown at, and where the point goes (0 = after digit 1)
    typedef struct packed {
        logic        op;
        logic [13:0] shown;
        logic [1:0]  dot_pos;
        logic        point;
    } scaled_t;

    typedef logic [DIGITS-1:0][7:0] seg_bytes_t;

    // active-low, bit 7 is the point (off)
    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] b;
        case (d)
            4'd0:    b = 8'hc0;
            4'd1:    b = 8'hf9;
            4'd2:    b = 8'ha4;
            4'd3:    b = 8'hb0;
            4'd4:    b = 8'h99;
            4'd5:    b = 8'h92;
            4'd6:    b = 8'h82;
            4'd7:    b = 8'hf8;
            4'd8:    b = 8'h80;
            4'd9:    b = 8'h90;
            default: b = 8'hff;
        endcase
        return b;
    endfunction

endpackage

// File: sv/seven_segment_autorange_scanner.sv
// Four-digit seven-segment autorange scanner.
// A tick item that completes a scan period passes the input register, the scale
// register and the output register before its digit shows on m_tvalid.
// Throughput: one item per cycle; a tick item waits while a digit sits unaccepted.
// Reset (rst_n low, async): digit store cleared, scan at digit 1, counter 0, period 2.
`timescale 1ns / 1ps

module seven_segment_autorange_scanner
    import ssas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [23:0] value_milli, [24] show_point, rest zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] segments, [10:8] digit_select, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    scaled_t    b_item;
    logic       b_valid;
    logic       b_consume;
    seg_bytes_t segs;
    logic [7:0] segments;
    logic [2:0] digit_select;

    assign cfg_ready = 1'b1;

    ssas_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata[23:0]),
        .in_point  (s_tdata[24]),
        .b_item    (b_item),
        .b_valid   (b_valid),
        .b_consume (b_consume)
    );

    ssas_digits u_digits (
        .item (b_item),
        .segs (segs)
    );

    ssas_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .b_item       (b_item),
        .b_valid      (b_valid),
        .segs         (segs),
        .b_consume    (b_consume),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_segments (segments),
        .out_select   (digit_select)
    );

    assign m_tdata = {5'd0, digit_select, segments};

endmodule

// File: sv/ssas_scale.sv
// Input register and autorange scaling: picks thousandths/hundredths/tenths/units.
// Depends on ssas_pkg; divisions by 10, 100, 1000 are reciprocal multiplies.
`timescale 1ns / 1ps

module ssas_scale
    import ssas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_op,
    input  logic [23:0] in_value,
    input  logic        in_point,
    output scaled_t     b_item,
    output logic        b_valid,
    input  logic        b_consume
);

    logic        a_valid_reg;
    logic        a_op_reg;
    logic [23:0] a_value_reg;
    logic        a_point_reg;
    logic        b_valid_reg;
    scaled_t     b_item_reg;
    scaled_t     b_item_next;

    logic        b_ready_in;
    logic        a_consume;

    logic [33:0] p10;
    logic [40:0] p100;
    logic [47:0] p1000;
    logic [14:0] q1000;

    assign b_ready_in = !b_valid_reg || b_consume;
    assign a_consume  = a_valid_reg && b_ready_in;
    assign in_ready   = !a_valid_reg || a_consume;

    // exact over the ranges each product is used on
    assign p10   = 34'(a_value_reg[16:0]) * 34'(17'd104858);
    assign p100  = 41'(a_value_reg[19:0]) * 41'(21'd1342178);
    assign p1000 = 48'(a_value_reg) * 48'(24'd8589935);
    assign q1000 = p1000[47:33];

    always_comb
    begin
        b_item_next.op    = a_op_reg;
        b_item_next.point = a_point_reg;
        if (a_value_reg < 24'd10000)
        begin
            b_item_next.shown   = a_value_reg[13:0];
            b_item_next.dot_pos = 2'd0;
        end
        else if (a_value_reg < 24'd100000)
        begin
            b_item_next.shown   = p10[33:20];
            b_item_next.dot_pos = 2'd1;
        end
        else if (a_value_reg < 24'd1000000)
        begin
            b_item_next.shown   = p100[40:27];
            b_item_next.dot_pos = 2'd2;
        end
        else
        begin
            b_item_next.shown   = (q1000 > 15'(SHOWN_MAX)) ? SHOWN_MAX : q1000[13:0];
            b_item_next.dot_pos = 2'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (b_ready_in)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_op_reg    <= in_op;
            a_value_reg <= in_value;
            a_point_reg <= in_point;
        end
        if (a_consume)
            b_item_reg <= b_item_next;
    end

    assign b_item  = b_item_reg;
    assign b_valid = b_valid_reg;

endmodule

// File: sv/ssas_digits.sv
// Splits a four-digit value into decimal digits and maps them to segment bytes.
// Depends on ssas_pkg (seg_code, scaled_t).
`timescale 1ns / 1ps

module ssas_digits
    import ssas_pkg::*;
(
    input  scaled_t    item,
    output seg_bytes_t segs
);

    logic [28:0] pk;
    logic [27:0] ph;
    logic [27:0] pt;
    logic [3:0]  q1000;
    logic [6:0]  q100;
    logic [9:0]  q10;
    logic [3:0]  d [DIGITS];

    // shown < 10000, so these reciprocals are exact
    assign pk    = 29'(item.shown) * 29'(15'd16778);
    assign ph    = 28'(item.shown) * 28'(14'd10486);
    assign pt    = 28'(item.shown) * 28'(14'd13108);
    assign q1000 = pk[27:24];
    assign q100  = ph[26:20];
    assign q10   = pt[26:17];

    always_comb
    begin
        logic [6:0]  t1;
        logic [9:0]  t2;
        logic [13:0] t3;
        t1   = q100 - 7'(q1000) * 7'd10;
        t2   = q10 - 10'(q100) * 10'd10;
        t3   = item.shown - 14'(q10) * 14'd10;
        d[0] = q1000;
        d[1] = t1[3:0];
        d[2] = t2[3:0];
        d[3] = t3[3:0];
    end

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            segs[i] = seg_code(d[i]);
            if (item.point && (item.dot_pos == 2'(i)))
                segs[i] = segs[i] & SEG_POINT_MASK;
        end
    end

endmodule

// File: sv/ssas_scan.sv
// Digit store, tick counter, scan position and output register.
// Depends on ssas_pkg; segment bytes arrive from ssas_digits.
`timescale 1ns / 1ps

module ssas_scan
    import ssas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  scaled_t     b_item,
    input  logic        b_valid,
    input  seg_bytes_t  segs,
    output logic        b_consume,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_segments,
    output logic [2:0]  out_select
);

    seg_bytes_t  digit_segments_reg;
    logic [15:0] tick_counter_reg;
    logic [15:0] tick_counter_next;
    logic [1:0]  scan_pos_reg;
    logic [15:0] period_reg;
    logic        out_valid_reg;
    logic [7:0]  out_segments_reg;
    logic [2:0]  out_select_reg;

    logic        take_tick;
    logic        emit;

    // updates never wait on the output side
    assign b_consume = b_valid && (b_item.op == OP_UPDATE || !out_valid_reg || out_ready);
    assign take_tick = b_consume && (b_item.op == OP_TICK);
    assign tick_counter_next = tick_counter_reg + 16'd1;
    assign emit = take_tick && (tick_counter_next >= period_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_segments_reg <= '0;
            tick_counter_reg   <= '0;
            scan_pos_reg       <= '0;
            period_reg         <= PERIOD_RESET;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                period_reg <= cfg_data;
            if (b_consume && b_item.op == OP_UPDATE)
                digit_segments_reg <= segs;
            if (take_tick)
                tick_counter_reg <= emit ? 16'd0 : tick_counter_next;
            if (emit)
            begin
                scan_pos_reg  <= scan_pos_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_segments_reg <= digit_segments_reg[scan_pos_reg];
            out_select_reg   <= 3'(scan_pos_reg) + 3'd1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_segments = out_segments_reg;
    assign out_select   = out_select_reg;

endmodule

// File: bench/tb_seven_segment_autorange_scanner.sv
// Testbench for seven_segment_autorange_scanner: value and tick items are sent in, and
// every digit that comes out is checked against a local prediction.
// Depends on ssas_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module tb_seven_segment_autorange_scanner;
    import ssas_pkg::*;

    localparam int RUN_LIMIT    = 1_500_000;
    localparam int DRAIN_LIMIT  = 20_000;
    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 9;
    localparam int LONG_TICKS   = 120;

    // active-low glyphs for 9 down to 0; digit d sits at bits [8*d +: 8]
    localparam logic [79:0] GLYPH_ROM = {8'h90, 8'h80, 8'hf8, 8'h82, 8'h92,
                                         8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0};

    typedef struct packed {
        logic [7:0] segments;
        logic [2:0] digit_select;
    } scan_digit_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [23:0] value_milli, [24] show_point, rest zero
    logic        s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] segments, [10:8] digit_select, rest zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predicted display state
    logic [7:0]  shown_glyphs [DIGITS];
    logic [1:0]  next_digit;
    logic [15:0] tick_count;
    logic [15:0] scan_period;

    scan_digit_t pending_digits [$];

    int error_count = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    seven_segment_autorange_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("tb_seven_segment_autorange_scanner: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch, cycle %0d: %s: got %0h, want %0h", cycle_count, what, got, want);
    endtask

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void load_display(input logic [23:0] v, input logic pt);
        int unsigned shown;
        int unsigned dot;
        int unsigned div;
        int unsigned digit;
        logic [7:0]  b;
        if (v < 24'd10000)
        begin
            shown = v;
            dot   = 0;
        end
        else if (v < 24'd100000)
        begin
            shown = v / 10;
            dot   = 1;
        end
        else if (v < 24'd1000000)
        begin
            shown = v / 100;
            dot   = 2;
        end
        else
        begin
            shown = v / 1000;
            if (shown > 9999)
                shown = 9999;
            dot = 3;
        end
        div = 1000;
        for (int i = 0; i < DIGITS; i++)
        begin
            digit = (shown / div) % 10;
            b = GLYPH_ROM[digit * 8 +: 8];
            if (pt && i == dot)
                b = b & SEG_POINT_MASK;
            shown_glyphs[i] = b;
            div = div / 10;
        end
    endfunction

    // counter goes up first, then compares; a period of 0 fires on every tick
    function automatic void count_tick();
        scan_digit_t d;
        tick_count = tick_count + 16'd1;
        if (tick_count >= scan_period)
        begin
            tick_count       = 16'd0;
            d.segments       = shown_glyphs[next_digit];
            d.digit_select   = {1'b0, next_digit} + 3'd1;
            pending_digits.push_back(d);
            next_digit       = next_digit + 2'd1;
        end
    endfunction

    always @(posedge clk)
    begin : check_output
        scan_digit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digits.size() == 0)
                report_mismatch("digit with none expected", m_tdata, 0);
            else
            begin
                want = pending_digits.pop_front();
                if (m_tdata[7:0] !== want.segments)
                    report_mismatch("segments", m_tdata[7:0], want.segments);
                if (m_tdata[10:8] !== want.digit_select)
                    report_mismatch("digit_select", m_tdata[10:8], want.digit_select);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            m_tready   = 1'b0;
            stall_left = idle_length();
        end
        else
            m_tready = 1'b1;
    end

    // called and returns at a falling edge
    task automatic send_item(input logic op, input logic [23:0] v, input logic pt);
        int gap;
        gap = gaps_on ? idle_length() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {7'd0, pt, v};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        if (op == OP_UPDATE)
            load_display(v, pt);
        else
            count_tick();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 24'($urandom), 1'($urandom));
    endtask

    task automatic write_period(input logic [15:0] p);
        cfg_data  = p;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        scan_period = p;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for every predicted digit; settle lets in-flight ticks finish before a write
    task automatic drain_results(input bit settle);
        int waited;
        waited = 0;
        while (pending_digits.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_digits.size() > 0)
        begin
            report_mismatch("digits never shown", 0, pending_digits.size());
            pending_digits.delete();
        end
        if (settle)
            repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:
            begin
                case ($urandom_range(0, 11))
                    0:  return 24'd0;
                    1:  return 24'd9999;
                    2:  return 24'd10000;
                    3:  return 24'd99999;
                    4:  return 24'd100000;
                    5:  return 24'd999999;
                    6:  return 24'd1000000;
                    7:  return 24'd9999999;
                    8:  return 24'd10000000;
                    9:  return 24'd9998999;
                    10: return 24'd9999000;
                    default: return 24'hffffff;
                endcase
            end
            1, 2:    return 24'($urandom_range(0, 9999));
            3:       return 24'($urandom_range(10000, 99999));
            4:       return 24'($urandom_range(100000, 999999));
            5, 6:    return 24'($urandom_range(1000000, 9999999));
            7:       return 24'($urandom_range(10000000, 16777215));
            8:       return 24'($urandom);
            default: return 24'($urandom_range(0, 99));
        endcase
    endfunction

    // all-zero store (every segment lit) after reset, default period of 2
    task automatic test_reset_scan();
        repeat (4) send_tick();
        drain_results(1'b1);
    endtask

    // 8888 with the point on digit 1 gives an all-lit byte; period 0 fires each tick
    task automatic test_zero_period();
        write_period(16'd0);
        send_item(OP_UPDATE, 24'd8888, 1'b1);
        repeat (4) send_tick();
        drain_results(1'b1);
    endtask

    task automatic test_range_edges();
        logic [23:0] edge_vals [6];
        edge_vals = '{24'hffffff, 24'd99999, 24'd1000000, 24'd9999, 24'd10000, 24'd0};
        write_period(16'd1);
        for (int i = 0; i < 6; i++)
        begin
            send_item(OP_UPDATE, edge_vals[i], 1'(i % 2 == 0));
            repeat (2) send_tick();
        end
        drain_results(1'b1);
    endtask

    // widest period holds digits back; a shorter period below the count fires on the next tick
    task automatic test_long_period();
        gaps_on = 1'b0;
        write_period(16'hffff);
        send_item(OP_UPDATE, rand_value(), 1'b1);
        repeat (LONG_TICKS) send_tick();
        drain_results(1'b1);
        write_period(16'd40);
        repeat (2) send_tick();
        drain_results(1'b1);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [15:0] p;
        int per_phase;
        per_phase = RANDOM_ITEMS / PHASES;
        for (int k = 0; k < PHASES; k++)
        begin
            case (k)
                0: p = 16'd1;
                1: p = 16'd3;
                2: p = 16'd2;
                3: p = 16'd5;
                4: p = 16'd0;
                5: p = 16'd1;
                6: p = 16'd4;
                7: p = 16'd11;
                default: p = 16'($urandom_range(1, 6));
            endcase
            gaps_on   = (k % 3 != 1);
            stalls_on = (k % 4 != 2);
            write_period(p);
            for (int n = 0; n < per_phase; n++)
            begin
                if ($urandom_range(0, 99) < 68)
                    send_tick();
                else
                    send_item(OP_UPDATE, rand_value(), 1'($urandom));
                if ($urandom_range(0, 149) == 0)
                    drain_results(1'b0);
            end
            drain_results(1'b1);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_UPDATE;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int i = 0; i < DIGITS; i++)
            shown_glyphs[i] = 8'h00;
        next_digit  = 2'd0;
        tick_count  = 16'd0;
        scan_period = PERIOD_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_scan();
        test_zero_period();
        test_range_edges();
        test_long_period();
        test_random_traffic();

        drain_results(1'b1);
        if (error_count == 0)
            $display("tb_seven_segment_autorange_scanner: clean");
        else
            $display("tb_seven_segment_autorange_scanner: errors");
        $finish;
    end

endmodule

// File: filelist.f
sv/ssas_pkg.sv
sv/ssas_scale.sv
sv/ssas_digits.sv
sv/ssas_scan.sv
sv/seven_segment_autorange_scanner.sv
bench/tb_seven_segment_autorange_scanner.sv
